// ===== rtl/core/cwg_pkg.sv =====
// Shared types, codes and calendar helper functions for the weekday and month grid core.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package cwg_pkg;

	localparam logic [15:0] MIN_YEAR    = 16'd1583;
	localparam logic [4:0]  LEAP_FEB    = 5'd29;
	localparam logic [4:0]  COMMON_FEB  = 5'd28;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned GRID_CELLS  = 42;
	localparam logic [2:0]  LAST_COLUMN = 3'd6;

	// floor(y/100) is estimated as (y*5242)>>19, at most one low for 16-bit y
	localparam logic [12:0] RECIP_100       = 13'd5242;
	localparam int unsigned RECIP_100_SHIFT = 19;
	// floor(s/7) is estimated as (s*2340)>>14, at most one low for 12-bit s
	localparam logic [11:0] RECIP_7         = 12'd2340;
	localparam int unsigned RECIP_7_SHIFT   = 14;

	localparam logic CMD_QUERY = 1'b0;
	localparam logic CMD_GRID  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_BAD_YEAR = 2'd1,
		STATUS_BAD_DATE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV7,
		ST_FIX,
		ST_EMIT
	} back_state_t;

	// One classified item as it sits in the queue between front and back.
	typedef struct packed {
		logic       grid;
		status_t    status;
		logic       leap;
		logic [4:0] len;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] k;
		logic [9:0] j;
	} job_t;

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] days;
		case (month) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
			4'd2:                                       days = leap ? LEAP_FEB : COMMON_FEB;
			default:                                    days = 5'd0;
		endcase
		return days;
	endfunction

	// floor((M+1)*2.6) with January and February counted as months 13 and 14
	function automatic logic [5:0] month_term(input logic [3:0] month);
		logic [5:0] t;
		case (month)
			4'd1:    t = 6'd36;
			4'd2:    t = 6'd39;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cwg_req_if.sv =====
// Request channel: command and date fields with a valid/ready handshake.
// Standalone; no package needed.
`default_nettype none

interface cwg_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [15:0] year_in;

	modport source(output valid, command, month_in, day_in, year_in, input ready);
	modport sink(input valid, command, month_in, day_in, year_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cwg_rsp_if.sv =====
// Response channel: one result beat per grid cell, or one per query or rejected request.
// Standalone; no package needed.
`default_nettype none

interface cwg_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] weekday;
	logic [4:0] month_length;
	logic       is_leap;
	logic [4:0] cell_day;
	logic [2:0] cell_column;
	logic       last;

	modport source(output valid, status, weekday, month_length, is_leap, cell_day,
		cell_column, last, input ready);
	modport sink(input valid, status, weekday, month_length, is_leap, cell_day,
		cell_column, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cwg_front.sv =====
// Front end: accepts a request, checks year, month and (queries only) day, finds leap year,
// month length and the century split of the Zeller year. Depends on cwg_pkg and cwg_req_if.
`default_nettype none

module cwg_front
	import cwg_pkg::*;
(
	cwg_req_if.sink  req,
	output logic     push_valid,
	input  logic     push_ready,
	output job_t     push_data
);

	logic [28:0] prod;
	logic [9:0]  q_est;
	logic [16:0] rem_est;
	logic        rem_over;
	logic [9:0]  cent;
	logic [6:0]  cent_rem;
	logic        leap;
	logic        early;
	logic [4:0]  len;
	logic        bad_day;
	status_t     status;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	always_comb begin
		prod     = 29'(req.year_in) * 29'(RECIP_100);
		q_est    = prod[RECIP_100_SHIFT +: 10];
		rem_est  = {1'b0, req.year_in} - 17'(q_est) * 17'd100;
		// estimate is at most one low: fold the remainder back under 100
		rem_over = rem_est[7:0] >= 8'd100;
		cent     = rem_over ? q_est + 10'd1 : q_est;
		cent_rem = rem_over ? 7'(rem_est[7:0] - 8'd100) : rem_est[6:0];
		leap     = (cent_rem == 7'd0) ? (cent[1:0] == 2'b00) : (req.year_in[1:0] == 2'b00);
		len      = month_days(req.month_in, leap);
		bad_day  = (req.day_in == 5'd0) || (req.day_in > len);

		if (req.year_in < MIN_YEAR) begin
			status = STATUS_BAD_YEAR;
		end else if (len == 5'd0) begin
			status = STATUS_BAD_DATE;
		end else if (req.command == CMD_QUERY && bad_day) begin
			status = STATUS_BAD_DATE;
		end else begin
			status = STATUS_OK;
		end

		early = req.month_in < 4'd3;

		push_data.grid   = (req.command == CMD_GRID) && (status == STATUS_OK);
		push_data.status = status;
		push_data.leap   = leap;
		push_data.len    = len;
		push_data.day    = (req.command == CMD_GRID) ? 5'd1 : req.day_in;
		push_data.month  = req.month_in;
		// January and February belong to the year before
		if (!early) begin
			push_data.k = cent_rem;
			push_data.j = cent;
		end else if (cent_rem == 7'd0) begin
			push_data.k = 7'd99;
			push_data.j = cent - 10'd1;
		end else begin
			push_data.k = cent_rem - 7'd1;
			push_data.j = cent;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cwg_queue.sv =====
// Short FIFO of classified jobs between front and back end.
// Depends on cwg_pkg for job_t.
`default_nettype none

module cwg_queue
	import cwg_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cwg_back.sv =====
// Back end: Zeller sum and mod 7 (SUM, DIV7, FIX), then one beat per query or grid cell.
// Depends on cwg_pkg and cwg_rsp_if.
`default_nettype none

module cwg_back
	import cwg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  job_t      pop_data,
	cwg_rsp_if.source rsp
);

	back_state_t state_q;
	back_state_t state_d;

	job_t        job_q;
	logic [11:0] sum_q;
	logic [9:0]  quot_q;
	logic [2:0]  wd_q;
	logic [2:0]  col_q;
	logic        row0_q;
	logic [5:0]  next_q;
	logic        over_q;
	logic [5:0]  cnt_q;

	logic [11:0] sum_c;
	logic [23:0] prod7;
	logic [11:0] rem7;
	logic [4:0]  cell_c;
	logic        take_c;
	logic        over_c;
	logic        last_c;
	logic        beat;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (pop_valid) state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV7;
			ST_DIV7: state_d = ST_FIX;
			ST_FIX:  state_d = ST_EMIT;
			ST_EMIT: if (rsp.ready && last_c) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop_ready        = state_q == ST_IDLE;
		rsp.valid        = state_q == ST_EMIT;
		rsp.status       = job_q.status;
		rsp.weekday      = (job_q.status == STATUS_OK) ? wd_q : 3'd0;
		rsp.month_length = job_q.len;
		rsp.is_leap      = job_q.leap;
		rsp.cell_day     = job_q.grid ? cell_c : 5'd0;
		rsp.cell_column  = job_q.grid ? col_q : 3'd0;
		rsp.last         = last_c;
	end

	assign beat = rsp.valid && rsp.ready;

	// Zeller: -2J is taken as +5J so the sum stays non-negative
	assign sum_c = 12'(job_q.day) + 12'(month_term(job_q.month)) + 12'(job_q.k)
		+ 12'(job_q.k[6:2]) + 12'(job_q.j[9:2]) + 12'(job_q.j) * 12'd5;
	assign prod7 = 24'(sum_q) * 24'(RECIP_7);
	assign rem7  = sum_q - 12'(quot_q) * 12'd7;

	// current grid cell
	always_comb begin
		cell_c = 5'd0;
		take_c = 1'b0;
		over_c = over_q;
		if (row0_q) begin
			if (col_q >= wd_q) begin
				cell_c = next_q[4:0];
				take_c = 1'b1;
			end
		end else if (!over_q && next_q <= {1'b0, job_q.len}) begin
			cell_c = next_q[4:0];
			take_c = 1'b1;
		end else begin
			over_c = 1'b1;
		end
		last_c = !job_q.grid || (cnt_q == 6'(GRID_CELLS - 1))
			|| (col_q == LAST_COLUMN && !row0_q && over_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q  <= pop_data;
				col_q  <= 3'd0;
				row0_q <= 1'b1;
				next_q <= 6'd1;
				over_q <= 1'b0;
				cnt_q  <= 6'd0;
			end
			ST_SUM: sum_q <= sum_c;
			ST_DIV7: quot_q <= prod7[RECIP_7_SHIFT +: 10];
			ST_FIX: wd_q <= (rem7[3:0] >= 4'd7) ? 3'(rem7[3:0] - 4'd7) : rem7[2:0];
			ST_EMIT: begin
				if (beat) begin
					// advance column, row and day counters
					col_q  <= (col_q == LAST_COLUMN) ? 3'd0 : col_q + 3'd1;
					row0_q <= row0_q && (col_q != LAST_COLUMN);
					next_q <= take_c ? next_q + 6'd1 : next_q;
					over_q <= over_c;
					cnt_q  <= cnt_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/calendar_weekday_and_month_grid_core.sv =====
// Top level of the weekday and month grid core: front end, job queue, back end.
// Depends on cwg_pkg, cwg_req_if, cwg_rsp_if, cwg_front, cwg_queue, cwg_back.
//
//  channel | dir | beat                                    | handshake
//  req     | in  | command, month_in, day_in, year_in      | valid/ready
//  rsp     | out | status, weekday, month_length, is_leap, | valid/ready
//          |     | cell_day, cell_column, last             |
//
// A request is classified as it is taken and queued (QUEUE_DEPTH entries).
// The back end loads an item, sums, divides by 7 and fixes the remainder, then emits
// one beat per query or error and one per grid cell; it pops the next item only when idle.
// rsp stalls hold the back end only; the front keeps taking requests until the queue fills.
// Reset clears the queue and returns the back end to idle.
`default_nettype none

module calendar_weekday_and_month_grid_core
	import cwg_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = cwg_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	cwg_req_if.sink   req,
	cwg_rsp_if.source rsp
);

	logic push_valid;
	logic push_ready;
	job_t push_data;
	logic pop_valid;
	logic pop_ready;
	job_t pop_data;

	cwg_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	cwg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	cwg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
